// ===== rtl/pdec_pkg.sv =====
// Shared types, constants and character helpers for the percent decoder.
`timescale 1ns / 1ps
`default_nettype none
package pdec_pkg;

  localparam int INDEX_W = 16;
  localparam int CFG_W   = 16;
  localparam int CMP_W   = (INDEX_W > CFG_W) ? INDEX_W : CFG_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0]   MAX_RESET = {CFG_W{1'b1}};
  localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] SLASH_CODE = 8'h01;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;

  localparam logic [1:0] PEND_NONE    = 2'd0;
  localparam logic [1:0] PEND_PERCENT = 2'd1;
  localparam logic [1:0] PEND_DIGIT   = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } res_item_t;

  // One accepted input's worth of results: cnt of 1 to 3 bytes.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            mark;
    logic            last;
  } req_t;

  typedef struct packed {
    logic push;
    req_t req;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_LOW_A) && (c <= CH_LOW_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (is_digit(c)) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pdec_front.sv =====
// Front end: accepts input bytes, tracks escapes and the index, builds requests.
`timescale 1ns / 1ps
`default_nettype none
module pdec_front
  import pdec_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             full,
  input  wire in_item_t         in_item,
  input  wire logic             cfg_valid,
  input  wire logic [CFG_W-1:0] cfg_data,
  output push_t                 push_out
);

  logic [1:0]         pend;
  logic [1:0]         pend_next;
  logic [7:0]         digit;
  logic [7:0]         digit_next;
  logic               sec_below;
  logic               sec_below_next;
  logic [INDEX_W-1:0] index;
  logic [INDEX_W-1:0] index_next;
  logic [CFG_W-1:0]   max_bytes;

  logic            accept;
  logic            below;
  logic            hex;
  logic            restart;
  logic [7:0]      b;
  logic [7:0]      decoded;
  logic [2:0][7:0] obuf;
  logic [1:0]      n;
  logic            mark;

  assign accept  = in_valid && !full;
  assign b       = in_item.in_byte;
  assign hex     = is_hex(b);
  assign below   = CMP_W'(index) < CMP_W'(max_bytes);
  assign decoded = ({hex_val(digit), hex_val(b)} == CH_SLASH) ? SLASH_CODE
                 : {hex_val(digit), hex_val(b)};

  always_comb begin
    pend_next      = pend;
    digit_next     = digit;
    sec_below_next = sec_below;
    index_next     = index;
    obuf           = '0;
    n              = 2'd0;
    mark           = 1'b0;
    restart        = 1'b0;
    unique case (pend)
      PEND_PERCENT: begin
        if (hex) begin
          pend_next      = PEND_DIGIT;
          digit_next     = b;
          sec_below_next = below;
        end else begin
          obuf[n]   = CH_PERCENT;
          n         = n + 2'd1;
          pend_next = PEND_NONE;
          restart   = 1'b1;
        end
      end
      PEND_DIGIT: begin
        pend_next = PEND_NONE;
        if (hex) begin
          obuf[n] = decoded;
          n       = n + 2'd1;
        end else begin
          obuf[n] = CH_PERCENT;
          n       = n + 2'd1;
          if (sec_below) begin
            obuf[n] = digit;
            n       = n + 2'd1;
          end
          restart = 1'b1;
        end
      end
      default: begin
        pend_next = PEND_NONE;
        restart   = 1'b1;
      end
    endcase
    if (restart && below) begin
      if (b == CH_PERCENT) begin
        pend_next = PEND_PERCENT;
      end else begin
        obuf[n] = b;
        n       = n + 2'd1;
      end
    end
    if (in_item.in_last) begin
      if (pend_next != PEND_NONE) begin
        obuf[n] = CH_PERCENT;
        n       = n + 2'd1;
      end
      if (pend_next == PEND_DIGIT && sec_below_next) begin
        obuf[n] = digit_next;
        n       = n + 2'd1;
      end
      pend_next = PEND_NONE;
      if (n == 2'd0) begin
        mark = 1'b1;
        n    = 2'd1;
      end
      index_next = '0;
    end else if (index != INDEX_MAX) begin
      index_next = index + INDEX_W'(1);
    end
  end

  always_comb begin
    push_out.push      = accept && (n != 2'd0);
    push_out.req.bytes = obuf;
    push_out.req.cnt   = n;
    push_out.req.mark  = mark;
    push_out.req.last  = in_item.in_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= PEND_NONE;
      sec_below <= 1'b0;
      index     <= '0;
      max_bytes <= MAX_RESET;
    end else begin
      if (cfg_valid) begin
        max_bytes <= cfg_data;
      end
      if (accept) begin
        pend      <= pend_next;
        sec_below <= sec_below_next;
        index     <= index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      digit <= digit_next;
    end
  end

  a_last_clears_index: assert property (@(posedge clk) disable iff (rst)
    accept && in_item.in_last |=> index == '0 && pend == PEND_NONE)
    else $error("index or escape not cleared after last byte");

endmodule
`default_nettype wire

// ===== rtl/pdec_queue.sv =====
// Short request queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module pdec_queue
  import pdec_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push_in,
  input  wire logic  pop,
  output logic       full,
  output logic       empty,
  output req_t       head
);

  req_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign head    = entries[rd_ptr];
  assign do_push = push_in.push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_in.req;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push_in.push)
    else $error("request pushed into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== rtl/pdec_back.sv =====
// Back end: unpacks queued requests into single result bytes.
`timescale 1ns / 1ps
`default_nettype none
module pdec_back
  import pdec_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic empty,
  input  wire req_t head,
  input  wire logic res_stall,
  output logic      pop,
  output logic      res_valid,
  output res_item_t res_item
);

  logic [1:0] pos;
  logic       load;
  logic       at_end;
  logic [7:0] sel_byte;

  assign load   = !res_valid || !res_stall;
  assign at_end = pos == (head.cnt - 2'd1);
  assign pop    = load && !empty && at_end;

  always_comb begin
    unique case (pos)
      2'd0:    sel_byte = head.bytes[0];
      2'd1:    sel_byte = head.bytes[1];
      default: sel_byte = head.bytes[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 2'd0;
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= !empty;
      if (!empty) begin
        pos <= at_end ? 2'd0 : pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      res_item.out_byte  <= sel_byte;
      res_item.out_valid <= !head.mark;
      res_item.out_last  <= head.last && at_end;
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> pos < head.cnt)
    else $error("result position beyond request size");

endmodule
`default_nettype wire

// ===== rtl/url_percent_decoder.sv =====
// Top level of the streaming URL percent decoder.
//
// Input channel: in_valid / in_stall with in_item (in_byte, in_last), one
// encoded byte per request. Result channel: res_valid / res_stall with
// res_item (out_byte, out_valid, out_last). Configuration: cfg_valid /
// cfg_ready / cfg_data writes max_input_bytes; cfg_ready is always high.
// The first result of an accepted byte goes through the request queue and then
// the result register onto res_item. The input takes one byte per cycle while
// each byte gives at most one result and res_stall is low; a byte that gives
// several results holds the result port until all are out, which the four-entry
// request queue between the front and back ends absorbs. in_stall rises only
// when that queue is full. Reset clears the escape state, the input index and
// the queue, and sets max_input_bytes to 65535. While res_stall is high the
// result register holds, the queue fills, and then in_stall is raised.
`timescale 1ns / 1ps
`default_nettype none
module url_percent_decoder
  import pdec_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_item,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output res_item_t             res_item,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);

  push_t push_req;
  req_t  head;
  logic  full;
  logic  empty;
  logic  pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;

  pdec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .full      (full),
    .in_item   (in_item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .push_out  (push_req)
  );

  pdec_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_in (push_req),
    .pop     (pop),
    .full    (full),
    .empty   (empty),
    .head    (head)
  );

  pdec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .res_stall (res_stall),
    .pop       (pop),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

endmodule
`default_nettype wire
